// ----- rtl/chmap_pkg.sv -----
`default_nettype none
package chmap_pkg;
    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
endpackage
`default_nettype wire

// ----- rtl/chained_hash_map_engine_top.sv -----
`default_nettype none
// Key-value store with separate chaining. Bucket heads, the entry pool and the in-use
// flags each live in a RAM with a registered read. A request (put, get or remove) walks
// its bucket chain, reading and then comparing each entry visited. A remove of an entry
// that is not the chain head also relinks its predecessor. A put of a new key scans the
// in-use flags from slot 0, one flag per cycle, for the lowest free slot, and answers
// full when the pool has none. An unused action code skips the walk and goes straight to
// the done state. One request is worked at a time, and the next one is taken the cycle
// after its result is handed to the output register; a stalled result holds the engine
// only when a second result is ready behind it. After reset a clearing pass empties every
// chain and in-use flag, during which no request is taken.
module chained_hash_map_engine_top
    import chmap_pkg::*;
#(
    parameter int ENTRIES = 1024,
    parameter int BUCKETS = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[1:0], key[33:2], value[65:34], zero fill to 72
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value[31:0], found[32], status[35:33], zero fill to 40
    output logic [39:0]      m_tdata
);
    localparam int EW = $clog2(ENTRIES);
    localparam int PW = EW + 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CLR_N = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
    localparam int CW = $clog2(CLR_N) + 1;
    localparam logic [PW-1:0] NO_ENTRY = PW'(ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_HEADW, S_RD, S_CMP, S_FREE, S_INS,
        S_RMRD, S_RMLINK, S_DONE
    } state_t;

    state_t         state_reg;
    logic [1:0]     act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [BW-1:0]  bkt_reg;
    logic [PW-1:0]  cur_reg, prev_reg, head_reg, slot_reg;
    logic [PW:0]    steps_reg;
    logic [PW-1:0]  count_reg;
    logic [CW-1:0]  clr_reg;
    logic           m_tvalid_reg;
    logic [39:0]    m_tdata_reg;
    logic [VAL_W-1:0] rd_reg;
    logic           found_reg;
    status_t        status_reg;

    // memories
    logic           hd_we;
    logic [BW-1:0]  hd_waddr, hd_raddr;
    logic [PW-1:0]  hd_wdata, hd_rdata;
    logic           en_we;
    logic [EW-1:0]  en_waddr, en_raddr;
    logic [KEY_W+VAL_W+PW-1:0] en_wdata, en_rdata;
    logic [KEY_W-1:0] e_key;
    logic [VAL_W-1:0] e_val;
    logic [PW-1:0]  e_link;
    logic           iu_we;
    logic [EW-1:0]  iu_waddr, iu_raddr;
    logic           iu_wdata, iu_rdata;

    chmap_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
        .aclk(aclk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rdata)
    );
    chmap_ram #(.WIDTH(KEY_W + VAL_W + PW), .DEPTH(ENTRIES)) u_entries (
        .aclk(aclk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
        .raddr(en_raddr), .rdata(en_rdata)
    );
    chmap_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_in_use (
        .aclk(aclk), .we(iu_we), .waddr(iu_waddr), .wdata(iu_wdata),
        .raddr(iu_raddr), .rdata(iu_rdata)
    );
    assign {e_link, e_val, e_key} = en_rdata;

    logic [15:0] fold;
    logic [BW:0] fold_lo;
    logic [BW-1:0] bkt_in;
    assign fold = s_tdata[17:2] ^ s_tdata[33:18];
    assign fold_lo = {1'b0, fold[BW-1:0]};
    assign bkt_in = (fold_lo >= (BW+1)'(BUCKETS)) ?
                    BW'(fold_lo - (BW+1)'(BUCKETS)) : fold_lo[BW-1:0];

    logic cur_ok;
    assign cur_ok = (cur_reg < NO_ENTRY);

    logic done_go;
    assign done_go = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        hd_we    = 1'b0;
        hd_waddr = bkt_reg;
        hd_wdata = NO_ENTRY;
        hd_raddr = bkt_reg;
        en_we    = 1'b0;
        en_waddr = slot_reg[EW-1:0];
        en_wdata = {head_reg, val_reg, key_reg};
        en_raddr = cur_reg[EW-1:0];
        iu_we    = 1'b0;
        iu_waddr = cur_reg[EW-1:0];
        iu_wdata = 1'b0;
        iu_raddr = '0;
        unique case (state_reg)
            S_CLEAR: begin
                hd_we    = (clr_reg < CW'(BUCKETS));
                hd_waddr = clr_reg[BW-1:0];
                iu_we    = (clr_reg < CW'(ENTRIES));
                iu_waddr = clr_reg[EW-1:0];
            end
            S_CMP: begin
                if (e_key == key_reg) begin
                    if (act_reg == ACT_PUT) begin
                        en_we    = 1'b1;
                        en_waddr = cur_reg[EW-1:0];
                        en_wdata = {e_link, val_reg, e_key};
                    end else if (act_reg == ACT_REMOVE) begin
                        iu_we = 1'b1;
                        if (prev_reg == NO_ENTRY) begin
                            hd_we    = 1'b1;
                            hd_wdata = e_link;
                        end
                    end
                end
            end
            S_FREE: begin
                iu_raddr = slot_reg[EW-1:0] + 1'b1;
            end
            S_INS: begin
                en_we    = 1'b1;
                hd_we    = 1'b1;
                hd_wdata = slot_reg;
                iu_we    = 1'b1;
                iu_waddr = slot_reg[EW-1:0];
                iu_wdata = 1'b1;
            end
            S_RMLINK: begin
                en_we    = 1'b1;
                en_waddr = prev_reg[EW-1:0];
                en_wdata = {head_reg, e_val, e_key};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (done_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CW'(CLR_N - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        act_reg    <= s_tdata[1:0];
                        key_reg    <= s_tdata[33:2];
                        val_reg    <= s_tdata[65:34];
                        bkt_reg    <= bkt_in;
                        rd_reg     <= '0;
                        found_reg  <= 1'b0;
                        status_reg <= ST_NOT_FOUND;
                        prev_reg   <= NO_ENTRY;
                        steps_reg  <= '0;
                        state_reg  <= (s_tdata[1:0] == ACT_NOP) ? S_DONE : S_HEAD;
                    end
                end
                S_HEAD: state_reg <= S_HEADW;
                S_HEADW: begin
                    cur_reg   <= hd_rdata;
                    head_reg  <= hd_rdata;
                    state_reg <= S_RD;
                end
                S_RD: begin
                    if (!cur_ok || steps_reg == (PW+1)'(ENTRIES)) begin
                        if (act_reg == ACT_PUT) begin
                            slot_reg  <= '0;
                            state_reg <= S_FREE;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (e_key == key_reg) begin
                        found_reg <= 1'b1;
                        unique case (act_reg)
                            ACT_PUT: begin
                                status_reg <= ST_UPDATED;
                                state_reg  <= S_DONE;
                            end
                            ACT_GET: begin
                                rd_reg     <= e_val;
                                status_reg <= ST_UPDATED;
                                state_reg  <= S_DONE;
                            end
                            default: begin
                                status_reg <= ST_REMOVED;
                                if (count_reg != '0) begin
                                    count_reg <= count_reg - 1'b1;
                                end
                                head_reg <= e_link;
                                if (prev_reg == NO_ENTRY) begin
                                    state_reg <= S_DONE;
                                end else begin
                                    cur_reg   <= prev_reg;
                                    state_reg <= S_RMRD;
                                end
                            end
                        endcase
                    end else begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= e_link;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_RMRD: state_reg <= S_RMLINK;
                S_RMLINK: state_reg <= S_DONE;
                S_FREE: begin
                    if (slot_reg == NO_ENTRY) begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_DONE;
                    end else if (!iu_rdata) begin
                        state_reg <= S_INS;
                    end else begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                S_INS: begin
                    count_reg  <= count_reg + 1'b1;
                    status_reg <= ST_INSERTED;
                    state_reg  <= S_DONE;
                end
                S_DONE: begin
                    if (done_go) begin
                        m_tdata_reg <= {4'd0, status_reg, found_reg, rd_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NO_ENTRY)
        else $error("entry count above pool size");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INS |-> count_reg < NO_ENTRY)
        else $error("insert into a full pool");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |-> cur_reg < NO_ENTRY)
        else $error("compare without an entry");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_tready)
        else $error("request taken while busy");
endmodule
`default_nettype wire

// ----- rtl/chmap_ram.sv -----
`default_nettype none
module chmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
